@@ src/tlbw_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, stream word layout and command codes of the TLB page walker.
package tlbw_pkg;

	// Page-table memory: fixed at 16K words of one frame number each.
	localparam int TABLE_WORDS = 16384;
	localparam int TABLE_AW    = 14;
	localparam int TABLE_DW    = 16;
	// Clear sweep counter: one bit more than the table address, the top bit marks completion.
	localparam int CLR_W       = TABLE_AW + 1;

	localparam int VA_W   = 32;
	localparam int CNT_W  = 32;
	localparam int PHYS_W = 16;

	// Defaults of the top-level parameters.
	localparam int DEF_TLB_DEPTH        = 64;
	localparam int DEF_PAGE_OFFSET_BITS = 12;
	localparam int DEF_VADDR_BITS       = 32;
	localparam int DEF_L2_INDEX_BITS    = 10;
	localparam int DEF_PHYS_PAGES       = 16;

	// Input word layout.
	localparam int S_VA_LSB  = 0;
	localparam int S_IDX_LSB = S_VA_LSB + VA_W;
	localparam int S_VAL_LSB = S_IDX_LSB + TABLE_AW;
	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 1;

	// Output word layout.
	localparam int M_PHYS_LSB = 0;
	localparam int M_HIT_LSB  = M_PHYS_LSB + PHYS_W;
	localparam int M_MISS_LSB = M_HIT_LSB + CNT_W;
	localparam int M_ACC_LSB  = M_MISS_LSB + CNT_W;
	localparam int M_TDATA_W  = M_ACC_LSB + CNT_W;
	localparam int M_TUSER_W  = 2;
	localparam int M_FAULT_BIT = 0;
	localparam int M_TLBHIT_BIT = 1;

	// Command carried in tuser.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

endpackage

@@ src/tlbw_sram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write and one registered read port.
module tlbw_sram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds between read enables.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/tlbw_slot_mod.sv @@
`timescale 1ns / 1ps
// Three-stage pipelined remainder of the virtual page number by the TLB depth.
module tlbw_slot_mod #(
	parameter int TLB_DEPTH = 64,
	parameter int VPN_W     = 20,
	parameter int SLOT_W    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [VPN_W-1:0]  vpn,
	output logic              out_valid,
	output logic [SLOT_W-1:0] slot
);

	localparam int DEP_W  = $clog2(TLB_DEPTH + 1);
	localparam int PROD_W = 2 * VPN_W + 1;
	localparam int WIDE_W = VPN_W + DEP_W;
	// Reciprocal scaled by 2^VPN_W, rounded down: the quotient estimate is low by at most one.
	localparam logic [VPN_W:0] RECIP = (VPN_W + 1)'((64'd1 << VPN_W) / 64'(TLB_DEPTH));
	localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(TLB_DEPTH);

	logic              valid_s1, valid_s2, valid_s3;
	logic [VPN_W-1:0]  vpn_s1, vpn_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [VPN_W-1:0]  prod_s2;
	logic [SLOT_W-1:0] slot_s3;
	logic [VPN_W-1:0]  quot;
	logic [WIDE_W-1:0] back_mul;
	logic [WIDE_W-1:0] rem;

	assign quot     = prod_s1[2*VPN_W-1:VPN_W];
	assign back_mul = WIDE_W'(quot) * DEPTH_W;
	assign rem      = WIDE_W'(vpn_s2 - prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		vpn_s1  <= vpn;
		prod_s1 <= PROD_W'(vpn) * PROD_W'(RECIP);
		vpn_s2  <= vpn_s1;
		prod_s2 <= back_mul[VPN_W-1:0];
		if (rem >= DEPTH_W) begin
			slot_s3 <= SLOT_W'(rem - DEPTH_W);
		end else begin
			slot_s3 <= SLOT_W'(rem);
		end
	end

	assign out_valid = valid_s3;
	assign slot      = slot_s3;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (WIDE_W'(slot) < DEPTH_W))
		else $error("slot remainder not below the TLB depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##3 out_valid)
		else $error("slot result did not appear three cycles after the request");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (prod_s2 <= vpn_s2))
		else $error("quotient estimate overshoots the page number");

endmodule

@@ src/tlb_two_level_page_walk.sv @@
`timescale 1ns / 1ps
// Flow: a write word goes from acceptance through the response state to the result register;
// a translation passes the slot remainder pipeline, the TLB lookup and the response state,
// and a miss adds a walk with two dependent page-table memory reads. Throughput: one word at
// a time; the next word is taken once the result register has taken the previous result.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the page-table memory
// and invalidates the TLB, and no input word is taken until it ends.
module tlb_two_level_page_walk #(
	parameter int TLB_DEPTH        = tlbw_pkg::DEF_TLB_DEPTH,
	parameter int PAGE_OFFSET_BITS = tlbw_pkg::DEF_PAGE_OFFSET_BITS,
	parameter int VADDR_BITS       = tlbw_pkg::DEF_VADDR_BITS,
	parameter int L2_INDEX_BITS    = tlbw_pkg::DEF_L2_INDEX_BITS,
	parameter int PHYS_PAGES       = tlbw_pkg::DEF_PHYS_PAGES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// virt_addr[31:0], table_word_index[45:32], table_word_value[61:46], zero padding
	input  logic [tlbw_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd[0]
	input  logic [tlbw_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// phys_addr[15:0], hit_count[47:16], miss_count[79:48], access_count[111:80]
	output logic [tlbw_pkg::M_TDATA_W-1:0]   m_tdata,
	// fault[0], tlb_hit[1]
	output logic [tlbw_pkg::M_TUSER_W-1:0]   m_tuser
);

	import tlbw_pkg::*;

	// Page number width; kept at one bit when the offset fills the whole address.
	localparam int VPN_W  = (VADDR_BITS > PAGE_OFFSET_BITS) ?
		VADDR_BITS - PAGE_OFFSET_BITS : 1;
	localparam int SLOT_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	// A TLB entry holds valid, tag and frame, valid in the top bit.
	localparam int TLB_W  = 1 + VPN_W + TABLE_DW;
	localparam logic [VA_W-1:0] VA_MASK  = VA_W'((64'd1 << VADDR_BITS) - 64'd1);
	localparam logic [VA_W-1:0] OFF_MASK = VA_W'((64'd1 << PAGE_OFFSET_BITS) - 64'd1);
	localparam logic [VA_W-1:0] L2_MASK  = VA_W'((64'd1 << L2_INDEX_BITS) - 64'd1);
	localparam logic [TABLE_DW:0] PHYS_LIMIT = (TABLE_DW + 1)'(PHYS_PAGES);
	localparam logic [CLR_W-1:0] TLB_CLR_END = CLR_W'(TLB_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT,
		ST_LOOK,
		ST_WALK,
		ST_RESP
	} state_t;

	state_t state_q;

	// Input word fields.
	logic [VA_W-1:0]     s_va;
	logic [TABLE_AW-1:0] s_idx;
	logic [TABLE_DW-1:0] s_val;
	logic                s_cmd;
	logic                accept;

	assign s_va   = s_tdata[S_VA_LSB +: VA_W];
	assign s_idx  = s_tdata[S_IDX_LSB +: TABLE_AW];
	assign s_val  = s_tdata[S_VAL_LSB +: TABLE_DW];
	assign s_cmd  = s_tuser[0];
	assign accept = s_tvalid && s_tready;

	// Clearing pass after reset: the top counter bit rises once every table word is zero.
	logic [CLR_W-1:0] clr_q;
	logic             clr_done;

	assign clr_done = clr_q[CLR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	// Item registers.
	logic [VADDR_BITS-1:0] va_q;
	logic [VPN_W-1:0]      vpn_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [VA_W-1:0]       va_ext;
	logic [VPN_W-1:0]      vpn_in;

	assign va_ext = VA_W'(va_q);
	assign vpn_in = VPN_W'((s_va & VA_MASK) >> PAGE_OFFSET_BITS);

	// Slot remainder pipeline.
	logic              mod_valid;
	logic [SLOT_W-1:0] mod_slot;

	tlbw_slot_mod #(
		.TLB_DEPTH (TLB_DEPTH),
		.VPN_W     (VPN_W),
		.SLOT_W    (SLOT_W)
	) u_slot_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && (s_cmd == CMD_XLATE)),
		.vpn       (vpn_in),
		.out_valid (mod_valid),
		.slot      (mod_slot)
	);

	// Memory ports.
	logic                tbl_we, tbl_re;
	logic [TABLE_AW-1:0] tbl_waddr, tbl_raddr;
	logic [TABLE_DW-1:0] tbl_wdata, tbl_rdata;
	logic                tlb_we, tlb_re;
	logic [SLOT_W-1:0]   tlb_waddr;
	logic [TLB_W-1:0]    tlb_wdata, tlb_rdata;

	tlbw_sram #(
		.DEPTH (TABLE_WORDS),
		.WIDTH (TABLE_DW),
		.AW    (TABLE_AW)
	) u_table_mem (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	tlbw_sram #(
		.DEPTH (TLB_DEPTH),
		.WIDTH (TLB_W),
		.AW    (SLOT_W)
	) u_tlb_mem (
		.clk   (clk),
		.we    (tlb_we),
		.waddr (tlb_waddr),
		.wdata (tlb_wdata),
		.re    (tlb_re),
		.raddr (mod_slot),
		.rdata (tlb_rdata)
	);

	// TLB entry fields as read back.
	logic                tlb_rd_valid;
	logic [VPN_W-1:0]    tlb_rd_tag;
	logic [TABLE_DW-1:0] tlb_rd_frame;
	logic                tlb_hit_c;

	assign tlb_rd_valid = tlb_rdata[TLB_W-1];
	assign tlb_rd_tag   = tlb_rdata[TABLE_DW +: VPN_W];
	assign tlb_rd_frame = tlb_rdata[TABLE_DW-1:0];
	assign tlb_hit_c    = tlb_rd_valid && (tlb_rd_tag == vpn_q);

	// Walk addresses: level one sits in frame zero; both wrap within the table memory.
	logic [TABLE_AW-1:0] l1_addr, l2_addr;

	assign l1_addr = TABLE_AW'(va_ext >> (PAGE_OFFSET_BITS + L2_INDEX_BITS));
	assign l2_addr = TABLE_AW'((VA_W'(tbl_rdata) << L2_INDEX_BITS) + (VA_W'(vpn_q) & L2_MASK));

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = clr_q[TABLE_AW-1:0];
		tbl_wdata = '0;
		tbl_re    = 1'b0;
		tbl_raddr = l1_addr;
		tlb_we    = 1'b0;
		tlb_waddr = slot_q;
		tlb_wdata = '0;
		tlb_re    = 1'b0;
		if (!clr_done) begin
			tbl_we = 1'b1;
			if (clr_q < TLB_CLR_END) begin
				tlb_we    = 1'b1;
				tlb_waddr = clr_q[SLOT_W-1:0];
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (accept && (s_cmd == CMD_WRITE)) begin
					tbl_we    = 1'b1;
					tbl_waddr = s_idx;
					tbl_wdata = s_val;
				end
			end
			ST_SLOT: begin
				// TLB entry and level-one word are fetched side by side.
				if (mod_valid) begin
					tlb_re = 1'b1;
					tbl_re = 1'b1;
				end
			end
			ST_LOOK: begin
				if (!tlb_hit_c) begin
					tbl_re    = 1'b1;
					tbl_raddr = l2_addr;
				end
			end
			ST_WALK: begin
				// Refill the slot, an unmapped frame included.
				tlb_we    = 1'b1;
				tlb_wdata = {1'b1, vpn_q, tbl_rdata};
			end
			default: begin
			end
		endcase
	end

	// Translation result from whichever frame this state sees.
	logic [TABLE_DW-1:0] frame_sel;
	logic                fault_c;
	logic [PHYS_W-1:0]   phys_c;

	assign frame_sel = (state_q == ST_LOOK) ? tlb_rd_frame : tbl_rdata;
	assign fault_c   = (frame_sel == '0) || ({1'b0, frame_sel} >= PHYS_LIMIT);
	assign phys_c    = fault_c ? '0 :
		PHYS_W'((VA_W'(frame_sel) << PAGE_OFFSET_BITS) + (va_ext & OFF_MASK));

	logic [CNT_W-1:0]  hit_cnt_q, miss_cnt_q, acc_cnt_q;
	logic              res_fault_q, res_hit_q;
	logic [PHYS_W-1:0] res_phys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			va_q        <= '0;
			vpn_q       <= '0;
			slot_q      <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			acc_cnt_q   <= '0;
			res_fault_q <= 1'b0;
			res_hit_q   <= 1'b0;
			res_phys_q  <= '0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= '0;
		end else begin
			// In the response state the output register is handled below.
			if (m_tvalid && m_tready && (state_q != ST_RESP)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						va_q  <= VADDR_BITS'(s_va);
						vpn_q <= vpn_in;
						if (s_cmd == CMD_WRITE) begin
							res_fault_q <= 1'b0;
							res_hit_q   <= 1'b0;
							res_phys_q  <= '0;
							state_q     <= ST_RESP;
						end else begin
							state_q <= ST_SLOT;
						end
					end
				end
				ST_SLOT: begin
					if (mod_valid) begin
						slot_q  <= mod_slot;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					acc_cnt_q <= acc_cnt_q + CNT_W'(1);
					if (tlb_hit_c) begin
						hit_cnt_q   <= hit_cnt_q + CNT_W'(1);
						res_fault_q <= fault_c;
						res_hit_q   <= 1'b1;
						res_phys_q  <= phys_c;
						state_q     <= ST_RESP;
					end else begin
						miss_cnt_q <= miss_cnt_q + CNT_W'(1);
						state_q    <= ST_WALK;
					end
				end
				ST_WALK: begin
					res_fault_q <= fault_c;
					res_hit_q   <= 1'b0;
					res_phys_q  <= phys_c;
					state_q     <= ST_RESP;
				end
				ST_RESP: begin
					// The output register takes the word once its previous one has gone.
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {acc_cnt_q, miss_cnt_q, hit_cnt_q, res_phys_q};
						m_tuser  <= {res_hit_q, res_fault_q};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE) && clr_done;

	assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !s_tready)
		else $error("input taken while the clearing pass runs");

	assert property (@(posedge clk) disable iff (!arst_n)
		(hit_cnt_q + miss_cnt_q) == acc_cnt_q)
		else $error("hit and miss counts do not add up to the lookup count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[M_FAULT_BIT]) |-> (m_tdata[M_PHYS_LSB +: PHYS_W] == '0))
		else $error("faulting translation carries a physical address");

	assert property (@(posedge clk) disable iff (!arst_n)
		(tlb_we && clr_done) |-> (tlb_wdata[TLB_W-1] && (state_q == ST_WALK)))
		else $error("TLB written outside a refill or without its valid bit");

endmodule

@@ tb/tlb_two_level_page_walk_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the two-level page walker and its direct-mapped TLB.
module tlb_two_level_page_walk_tb;
	import tlbw_pkg::*;

	// The block is built with its default parameters, so the predictor uses the same figures.
	localparam int SLOTS      = DEF_TLB_DEPTH;
	localparam int OFF_BITS   = DEF_PAGE_OFFSET_BITS;
	localparam int VA_BITS    = DEF_VADDR_BITS;
	localparam int L2_BITS    = DEF_L2_INDEX_BITS;
	localparam int NUM_FRAMES = DEF_PHYS_PAGES;
	localparam int L1_LAST    = (1 << (VA_BITS - OFF_BITS - L2_BITS)) - 1;
	localparam int L2_LAST    = (1 << L2_BITS) - 1;
	localparam int OFF_LAST   = (1 << OFF_BITS) - 1;
	localparam int MAX_GAP    = 10;
	localparam int MAX_REPORTS = 50;

	// One translation result as it should leave the block.
	typedef struct {
		logic                fault;
		logic [PHYS_W-1:0]   phys;
		logic                tlb_hit;
		logic [CNT_W-1:0]    hits;
		logic [CNT_W-1:0]    misses;
		logic [CNT_W-1:0]    lookups;
	} xlate_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	tlb_two_level_page_walk dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Shadow copy of the translator: TLB, page-table memory and the three counters.
	// All of it starts at zero, which matches the state after the clearing pass.
	bit [63:0]         shadow_vpn   [SLOTS];
	bit [TABLE_DW-1:0] shadow_frame [SLOTS];
	bit                shadow_valid [SLOTS];
	bit [TABLE_DW-1:0] page_words   [TABLE_WORDS];
	bit [CNT_W-1:0]    hit_ctr;
	bit [CNT_W-1:0]    miss_ctr;
	bit [CNT_W-1:0]    lookup_ctr;

	// Translations the block still owes us, oldest first.
	xlate_result_t owed_results[$];

	// Recently mapped virtual pages, revisited to provoke hits, stale entries and evictions.
	bit [VA_BITS-OFF_BITS-1:0] page_pool [16];

	int  error_count = 0;
	int  words_sent  = 0;
	int  stall_left  = 0;
	bit  quiet_phase = 1'b0;

	// Idle cycles before the next word on either side; none at all in a quiet phase.
	function automatic int pick_gap();
		if (quiet_phase)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Applies one input word to the shadow state and returns the result it should produce.
	function automatic xlate_result_t predict_translation(logic cmd, logic [VA_W-1:0] va,
			logic [TABLE_AW-1:0] idx, logic [TABLE_DW-1:0] val);
		xlate_result_t     r;
		logic [63:0]       va_eff;
		logic [63:0]       offset;
		logic [63:0]       vpn;
		logic [63:0]       l1;
		logic [63:0]       l2;
		logic [63:0]       walk_addr;
		logic [63:0]       phys_full;
		logic [TABLE_DW-1:0] l2frame;
		logic [TABLE_DW-1:0] frame;
		int                slot;

		r.fault   = 1'b0;
		r.phys    = '0;
		r.tlb_hit = 1'b0;
		if (cmd == CMD_WRITE) begin
			page_words[idx] = val;
		end else begin
			va_eff = {32'b0, va} & ((64'd1 << VA_BITS) - 1);
			offset = va_eff & ((64'd1 << OFF_BITS) - 1);
			vpn    = va_eff >> OFF_BITS;
			l2     = vpn & ((64'd1 << L2_BITS) - 1);
			l1     = vpn >> L2_BITS;
			slot   = int'(vpn % SLOTS);
			lookup_ctr++;
			if (shadow_valid[slot] && shadow_vpn[slot] == vpn) begin
				hit_ctr++;
				r.tlb_hit = 1'b1;
				frame = shadow_frame[slot];
			end else begin
				// Both page-table reads wrap round the memory, so a wild L2 frame still lands.
				miss_ctr++;
				l2frame   = page_words[l1 % TABLE_WORDS];
				walk_addr = ({48'b0, l2frame} << L2_BITS) + l2;
				frame     = page_words[walk_addr % TABLE_WORDS];
				shadow_vpn[slot]   = vpn;
				shadow_frame[slot] = frame;
				shadow_valid[slot] = 1'b1;
			end
			if (frame == 0 || frame >= NUM_FRAMES) begin
				r.fault = 1'b1;
			end else begin
				phys_full = ({48'b0, frame} << OFF_BITS) + offset;
				r.phys    = phys_full[PHYS_W-1:0];
			end
		end
		r.hits    = hit_ctr;
		r.misses  = miss_ctr;
		r.lookups = lookup_ctr;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
		if (error_count < MAX_REPORTS)
			$display("%0t ns: %s wrong, got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic check_field(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Sends one word and records its expected result once the block has taken it. The valid
	// line is only lowered when a gap follows, so it never sees two updates in one step.
	task automatic send_word(logic cmd, logic [VA_W-1:0] va, logic [TABLE_AW-1:0] idx,
			logic [TABLE_DW-1:0] val);
		logic [S_TDATA_W-1:0] payload;
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		payload = '0;
		payload[S_VA_LSB +: VA_W]      = va;
		payload[S_IDX_LSB +: TABLE_AW] = idx;
		payload[S_VAL_LSB +: TABLE_DW] = val;
		s_tvalid <= 1'b1;
		s_tdata  <= payload;
		s_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_tready);
		owed_results.push_back(predict_translation(cmd, va, idx, val));
		words_sent++;
	endtask

	// The unused fields of each word carry random values, so their bits toggle as well.
	task automatic write_word(int idx, int val);
		send_word(CMD_WRITE, $urandom(), TABLE_AW'(idx), TABLE_DW'(val));
	endtask

	task automatic translate(logic [VA_W-1:0] va);
		send_word(CMD_XLATE, va, TABLE_AW'($urandom_range(0, TABLE_WORDS - 1)),
			TABLE_DW'($urandom_range(0, 65535)));
	endtask

	// Holds the input back until every owed result has come, then lets the walker settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [VA_W-1:0] make_va(int l1, int l2, int off);
		return (VA_W'(l1) << (OFF_BITS + L2_BITS)) | (VA_W'(l2) << OFF_BITS) | VA_W'(off);
	endfunction

	// Hand-picked words: field extremes, a fault on an unmapped page and on a frame past the
	// physical pages, a walk through a wrapped L2 frame, a stale TLB entry and an eviction.
	task automatic test_directed_walks();
		translate('0);
		translate('1);
		write_word(TABLE_WORDS - 1, 16'hFFFF);
		write_word(0, 0);
		// L1 entry 1 points at frame 3; its entry 5 maps to frame 7.
		write_word(1, 3);
		write_word(3 * 1024 + 5, 7);
		translate(make_va(1, 5, 12'hABC));
		translate(make_va(1, 5, 12'h123));
		// Frame number equal to the physical page count is out of range, even from the TLB.
		write_word(3 * 1024 + 6, NUM_FRAMES);
		translate(make_va(1, 6, 0));
		translate(make_va(1, 6, 12'h001));
		// The highest frame with the highest offset gives the top physical address.
		write_word(3 * 1024 + 7, NUM_FRAMES - 1);
		translate(make_va(1, 7, OFF_LAST));
		// L1 entry 2 names a frame far beyond the memory; the walk wraps into frame 15.
		write_word(2, 16'hFFFF);
		write_word(15 * 1024 + 9, 4);
		translate(make_va(2, 9, 12'h055));
		// Remapping without a flush leaves the old translation live in the TLB.
		write_word(3 * 1024 + 5, 9);
		translate(make_va(1, 5, 0));
		// Same slot, different tag: the newcomer evicts it and the next walk sees frame 9.
		translate(make_va(1, 5 + SLOTS, 0));
		translate(make_va(1, 5, 12'h010));
		translate(make_va(1, 5, 12'h020));
	endtask

	// Well-formed mappings with random content: set the L1 and L2 words, then translate the
	// page a few times. Some sequences are broken on purpose: a missing L1 write, an unmapped
	// or out-of-range frame, or an L2 frame that wraps round the memory.
	task automatic test_mapped_walks(int sequences);
		int l1;
		int l2;
		int l2frame;
		int frame;
		int kind;
		bit [VA_BITS-OFF_BITS-1:0] vpn;

		repeat (sequences) begin
			l1   = $urandom_range(0, L1_LAST);
			l2   = $urandom_range(0, L2_LAST);
			kind = $urandom_range(0, 9);
			l2frame = (kind == 0) ? $urandom_range(NUM_FRAMES, 65535) :
				$urandom_range(1, NUM_FRAMES - 1);
			frame = (kind == 1) ? 0 :
				(kind == 2) ? $urandom_range(NUM_FRAMES, 65535) :
				$urandom_range(1, NUM_FRAMES - 1);
			if (kind != 3)
				write_word(l1, l2frame);
			write_word(((l2frame << L2_BITS) + l2) % TABLE_WORDS, frame);
			vpn = (VA_BITS - OFF_BITS)'((l1 << L2_BITS) | l2);
			repeat ($urandom_range(1, 4))
				translate({vpn, OFF_BITS'($urandom_range(0, OFF_LAST))});
			page_pool[$urandom_range(0, 15)] = vpn;
			if ($urandom_range(0, 2) == 0)
				translate({page_pool[$urandom_range(0, 15)], OFF_BITS'($urandom())});
		end
	endtask

	// The same walks with neither side idling, so words follow each other at full rate.
	task automatic test_back_to_back(int sequences);
		quiet_phase = 1'b1;
		test_mapped_walks(sequences);
		quiet_phase = 1'b0;
	endtask

	// Unstructured traffic: random table writes anywhere and random addresses, with a share
	// of revisits to pages that were mapped earlier.
	task automatic test_random_noise(int count);
		repeat (count) begin
			case ($urandom_range(0, 3))
				0, 1: write_word($urandom_range(0, TABLE_WORDS - 1), $urandom_range(0, 65535));
				2: translate($urandom());
				default: translate({page_pool[$urandom_range(0, 15)], OFF_BITS'($urandom())});
			endcase
		end
	endtask

	// Result side: after each result word it holds tready low for a drawn number of cycles.
	always @(posedge clk) begin : ready_driver
		int gap;

		if (m_tvalid && m_tready) begin
			gap = pick_gap();
			stall_left <= gap;
			m_tready   <= (gap == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every result word taken is matched against the oldest owed result, field by field.
	always @(posedge clk) begin : result_check
		xlate_result_t want;

		if (m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				report_mismatch("unrequested result, phys_addr",
					CNT_W'(m_tdata[M_PHYS_LSB +: PHYS_W]), '0);
			end else begin
				want = owed_results.pop_front();
				check_field("fault", CNT_W'(m_tuser[M_FAULT_BIT]), CNT_W'(want.fault));
				check_field("tlb_hit", CNT_W'(m_tuser[M_TLBHIT_BIT]), CNT_W'(want.tlb_hit));
				check_field("phys_addr", CNT_W'(m_tdata[M_PHYS_LSB +: PHYS_W]),
					CNT_W'(want.phys));
				check_field("hit_count", m_tdata[M_HIT_LSB +: CNT_W], want.hits);
				check_field("miss_count", m_tdata[M_MISS_LSB +: CNT_W], want.misses);
				check_field("access_count", m_tdata[M_ACC_LSB +: CNT_W], want.lookups);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its memory first; send_word simply waits on tready until then.
		test_directed_walks();
		drain_results();
		test_back_to_back(40);
		test_mapped_walks(200);
		drain_results();
		test_random_noise(550);
		drain_results();
		if (owed_results.size() != 0)
			report_mismatch("results still owed", CNT_W'(owed_results.size()), '0);
		$display("Run covered %0d words: %0d translations with %0d TLB hits and %0d misses.",
			words_sent, lookup_ctr, hit_ctr, miss_ctr);
		$display("Mixed faults, wrapped walks, stale entries and evictions under random stalls.");
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this, clearing pass included.
	initial begin
		#10_000_000;
		$display("Timed out with %0d results still owed.", owed_results.size());
		$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
src/tlbw_pkg.sv
src/tlbw_sram.sv
src/tlbw_slot_mod.sv
src/tlb_two_level_page_walk.sv
tb/tlb_two_level_page_walk_tb.sv
